// File: rtl/core/bprf_pkg.sv
// Shared constants, types and helpers for the batched-publish ring FIFO.
package bprf_pkg;

  localparam int CAPACITY = 1024;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int STEP_W   = 8;
  localparam int ADDR_W   = 3;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [0:0] REG_PUBLISH_STEP = 1'b0;

  localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(10);
  localparam logic [STEP_W-1:0] COUNT_RESET = STEP_W'(1);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic we;
    logic re;
    ptr_t addr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic is_pop;
  } result_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == ptr_t'(CAPACITY - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

// File: rtl/core/bprf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module bprf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bprf_ctrl.sv
// Pointer, batch-count and publication logic of the ring FIFO.
module bprf_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [1:0]                     op,
  input  logic                           partner_gone,
  input  logic [bprf_pkg::STEP_W-1:0]    publish_step,
  output bprf_pkg::mem_req_t             mem_req,
  output bprf_pkg::result_t              result
);

  bprf_pkg::ptr_t tail_r, tail_nxt;
  bprf_pkg::ptr_t pub_tail_r, pub_tail_nxt;
  bprf_pkg::ptr_t head_r, head_nxt;
  bprf_pkg::ptr_t pub_head_r, pub_head_nxt;
  logic [bprf_pkg::STEP_W-1:0] push_cnt_r, push_cnt_nxt;
  logic [bprf_pkg::STEP_W-1:0] pop_cnt_r, pop_cnt_nxt;
  bprf_pkg::result_t result_r, result_nxt;
  bprf_pkg::ptr_t tail_inc, head_inc;

  assign tail_inc = bprf_pkg::ring_next(tail_r);
  assign head_inc = bprf_pkg::ring_next(head_r);

  always_comb begin
    tail_nxt     = tail_r;
    pub_tail_nxt = pub_tail_r;
    head_nxt     = head_r;
    pub_head_nxt = pub_head_r;
    push_cnt_nxt = push_cnt_r;
    pop_cnt_nxt  = pop_cnt_r;
    mem_req      = '{we: 1'b0, re: 1'b0, addr: tail_r};
    result_nxt   = '{valid: accept, ok: 1'b0, is_pop: 1'b0};
    if (accept) begin
      unique case (op)
        bprf_pkg::OP_PUSH: begin
          if (tail_inc == pub_head_r) begin
            if (partner_gone) begin
              pub_head_nxt = head_r;
            end
          end else begin
            mem_req.we    = 1'b1;
            tail_nxt      = tail_inc;
            result_nxt.ok = 1'b1;
            if (push_cnt_r == publish_step) begin
              push_cnt_nxt = bprf_pkg::COUNT_RESET;
              pub_tail_nxt = tail_inc;
            end else begin
              push_cnt_nxt = push_cnt_r + 1'b1;
            end
          end
        end
        bprf_pkg::OP_POP: begin
          mem_req.addr = head_r;
          if (head_r == pub_tail_r) begin
            if (partner_gone) begin
              pub_tail_nxt = tail_r;
            end
          end else begin
            mem_req.re        = 1'b1;
            head_nxt          = head_inc;
            result_nxt.ok     = 1'b1;
            result_nxt.is_pop = 1'b1;
            if (pop_cnt_r == publish_step) begin
              pop_cnt_nxt  = bprf_pkg::COUNT_RESET;
              pub_head_nxt = head_inc;
            end else begin
              pop_cnt_nxt = pop_cnt_r + 1'b1;
            end
          end
        end
        bprf_pkg::OP_FLUSH: begin
          pub_tail_nxt  = tail_r;
          result_nxt.ok = 1'b1;
        end
        default: begin
          result_nxt.ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r     <= '0;
      pub_tail_r <= '0;
      head_r     <= '0;
      pub_head_r <= '0;
      push_cnt_r <= bprf_pkg::COUNT_RESET;
      pop_cnt_r  <= bprf_pkg::COUNT_RESET;
      result_r   <= '0;
    end else begin
      tail_r     <= tail_nxt;
      pub_tail_r <= pub_tail_nxt;
      head_r     <= head_nxt;
      pub_head_r <= pub_head_nxt;
      push_cnt_r <= push_cnt_nxt;
      pop_cnt_r  <= pop_cnt_nxt;
      result_r   <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// File: rtl/core/batched_publish_ring_fifo.sv
// Top level of the batched-publish ring FIFO: configuration port, control and slot memory.
//
// The block takes one command (push, pop or flush) in every clock cycle: busy
// never rises, and the result word appears on the out_ ports in the cycle
// after the command is taken, marked by out_valid for that single cycle. The
// result flags are registered, as is the read port of the slot memory,
// which a pop reads at the reader's private head; the pointer and batch-count
// registers update at the same edge, so the next command sees them at once.
// The receiver cannot stall, so every result must be captured when it is
// shown. The slot memory needs no clearing after reset: a pop only ever
// reaches slots that an earlier push has written, so commands are taken from
// the first cycle after reset. The publication interval sits in the single
// configuration register at byte address 0 and should only be changed while
// no result is pending.
module batched_publish_ring_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic signed [bprf_pkg::DATA_W-1:0]  in_push_value,
  input  logic                                in_partner_gone,
  // Result channel.
  output logic                                out_valid,
  output logic                                out_ok,
  output logic signed [bprf_pkg::DATA_W-1:0]  out_pop_value,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bprf_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [bprf_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        cfg_write;
  logic                        accept;
  bprf_pkg::mem_req_t          mem_req;
  bprf_pkg::result_t           result;
  logic [bprf_pkg::DATA_W-1:0] rd_data;

  // The block never holds off a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register: the publication interval. Writes to any other
  // word address are dropped, and such reads return zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    step_nxt = step_r;
    if (cfg_write && (paddr[2] == bprf_pkg::REG_PUBLISH_STEP)) begin
      step_nxt = pwdata[bprf_pkg::STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bprf_pkg::STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign prdata = (paddr[2] == bprf_pkg::REG_PUBLISH_STEP) ?
                  {{(32 - bprf_pkg::STEP_W){1'b0}}, step_r} : 32'd0;

  // Pointer and publication control.
  bprf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_op),
    .partner_gone (in_partner_gone),
    .publish_step (step_r),
    .mem_req      (mem_req),
    .result       (result)
  );

  // Slot storage. A push writes at the private tail and a pop reads at the
  // private head; both use the address chosen by the control block.
  bprf_ram #(
    .WIDTH (bprf_pkg::DATA_W),
    .DEPTH (bprf_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.addr),
    .wdata (in_push_value),
    .re    (mem_req.re),
    .raddr (mem_req.addr),
    .rdata (rd_data)
  );

  // The read word is only passed on for a successful pop; every other
  // result carries zero.
  assign out_valid     = result.valid;
  assign out_ok        = result.ok;
  assign out_pop_value = result.is_pop ? $signed(rd_data) : '0;

endmodule
